### rtl/core/pkcr_pkg.sv
// ----------------------------------------------------------------------------
// pkcr_pkg: shared types and codes of the PS/2 keyboard command responder
// Command and response byte codes, configuration register indexes, and the
// run descriptor that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package pkcr_pkg;

  // Longest response run for one received byte
  localparam int unsigned RunMax     = 3;
  localparam int unsigned RunIdxW    = $clog2(RunMax);
  localparam int unsigned QueueDepth = 2;

  // Configuration port
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CFG_KEY_EMU  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_INIT_SET = 8'd1;

  // Reset values
  localparam logic       KeyEmuReset  = 1'b1;
  localparam logic [7:0] InitSetReset = 8'h02;

  // Host commands
  localparam logic [7:0] CMD_LEDS      = 8'hED;
  localparam logic [7:0] CMD_ECHO      = 8'hEE;
  localparam logic [7:0] CMD_BAD_EF    = 8'hEF;
  localparam logic [7:0] CMD_SET       = 8'hF0;
  localparam logic [7:0] CMD_BAD_F1    = 8'hF1;
  localparam logic [7:0] CMD_READ_ID   = 8'hF2;
  localparam logic [7:0] CMD_TYPEMATIC = 8'hF3;
  localparam logic [7:0] CMD_ENABLE    = 8'hF4;
  localparam logic [7:0] CMD_RESEND    = 8'hFE;
  localparam logic [7:0] CMD_RESET     = 8'hFF;

  // Keyboard responses
  localparam logic [7:0] RSP_ACK    = 8'hFA;
  localparam logic [7:0] RSP_RESEND = 8'hFE;
  localparam logic [7:0] RSP_ECHO   = 8'hEE;
  localparam logic [7:0] RSP_BAT_OK = 8'hAA;
  localparam logic [7:0] RSP_ID_LO  = 8'hAB;
  localparam logic [7:0] RSP_ID_HI  = 8'h83;

  // LED argument limit (exclusive)
  localparam logic [7:0] LED_ARG_LIMIT = 8'h07;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic       kbd_enabled;
    logic [2:0] led_bits;
    logic       leds_valid;
    byte_t      current_set;
    logic [1:0] table_choice;
  } status_t;

  typedef struct packed {
    byte_t [RunMax-1:0]  bytes;
    logic  [RunIdxW-1:0] last_idx;
    status_t             status;
  } run_t;

endpackage

### rtl/core/pkcr_front.sv
// ----------------------------------------------------------------------------
// pkcr_front: command decoder and keyboard state
// Classifies each received byte, updates the keyboard state and builds the
// response run descriptor pushed into the queue.
// ----------------------------------------------------------------------------
module pkcr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          rx_error_i,
  input  logic                          cfg_we_i,
  input  logic [pkcr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pkcr_pkg::CfgDataW-1:0] cfg_data_i,
  output pkcr_pkg::run_t                run_o
);

  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_TYPEMATIC = 2'd1;
  localparam logic [1:0] PH_SET       = 2'd2;
  localparam logic [1:0] PH_LED       = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [7:0] last_sent_q, last_sent_d;
  logic       enable_q, enable_d;
  logic [7:0] set_q, set_d;
  logic [1:0] table_q, table_d;
  logic [2:0] led_q, led_d;
  logic       led_vld_q, led_vld_d;
  logic       key_emu_q;

  pkcr_pkg::run_t run;

  always_comb begin
    phase_d   = phase_q;
    enable_d  = enable_q;
    set_d     = set_q;
    table_d   = table_q;
    led_d     = led_q;
    led_vld_d = led_vld_q;
    run.bytes    = {pkcr_pkg::RunMax{pkcr_pkg::RSP_ACK}};
    run.last_idx = '0;

    if (phase_q == PH_IDLE) begin
      if (rx_error_i || (rx_byte_i < pkcr_pkg::CMD_LEDS) ||
          (rx_byte_i == pkcr_pkg::CMD_BAD_F1) || (rx_byte_i == pkcr_pkg::CMD_BAD_EF)) begin
        run.bytes[0] = pkcr_pkg::RSP_RESEND;
      end else begin
        case (rx_byte_i)
          pkcr_pkg::CMD_RESET: begin
            enable_d = 1'b0;
            if (key_emu_q) begin
              run.bytes[1] = pkcr_pkg::RSP_BAT_OK;
              run.last_idx = pkcr_pkg::RunIdxW'(1);
            end
          end
          pkcr_pkg::CMD_RESEND:    run.bytes[0] = last_sent_q;
          pkcr_pkg::CMD_ENABLE:    enable_d = 1'b1;
          pkcr_pkg::CMD_READ_ID: begin
            run.bytes[1] = pkcr_pkg::RSP_ID_LO;
            run.bytes[2] = pkcr_pkg::RSP_ID_HI;
            run.last_idx = pkcr_pkg::RunIdxW'(2);
            enable_d     = 1'b1;
          end
          pkcr_pkg::CMD_ECHO:      run.bytes[0] = pkcr_pkg::RSP_ECHO;
          pkcr_pkg::CMD_TYPEMATIC: phase_d = PH_TYPEMATIC;
          pkcr_pkg::CMD_SET:       phase_d = PH_SET;
          pkcr_pkg::CMD_LEDS:      phase_d = PH_LED;
          default:                 run.bytes[0] = pkcr_pkg::RSP_ACK;
        endcase
      end
    end else if (rx_error_i) begin
      // stay in the phase, ask for the argument again
      run.bytes[0] = pkcr_pkg::RSP_RESEND;
    end else begin
      phase_d = PH_IDLE;
      case (phase_q)
        PH_SET: begin
          if (rx_byte_i == 8'h00) begin
            run.bytes[1] = set_q;
            run.last_idx = pkcr_pkg::RunIdxW'(1);
          end else begin
            set_d = rx_byte_i;
            if (rx_byte_i inside {[8'd1:8'd3]}) begin
              table_d = rx_byte_i[1:0];
            end
          end
        end
        PH_LED: begin
          if (rx_byte_i < pkcr_pkg::LED_ARG_LIMIT) begin
            led_d     = rx_byte_i[2:0];
            led_vld_d = 1'b1;
          end
        end
        default: run.bytes[0] = pkcr_pkg::RSP_ACK;
      endcase
    end

    // track the last real byte sent, skipping resend requests
    last_sent_d = last_sent_q;
    for (int k = 0; k < pkcr_pkg::RunMax; k++) begin
      if ((pkcr_pkg::RunIdxW'(k) <= run.last_idx) &&
          (run.bytes[k] != pkcr_pkg::RSP_RESEND)) begin
        last_sent_d = run.bytes[k];
      end
    end

    run.status.kbd_enabled  = enable_d;
    run.status.led_bits     = led_d;
    run.status.leds_valid   = led_vld_d;
    run.status.current_set  = set_d;
    run.status.table_choice = table_d;
  end

  assign run_o = run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      last_sent_q <= 8'h00;
      enable_q    <= 1'b0;
      set_q       <= pkcr_pkg::InitSetReset;
      table_q     <= 2'd0;
      led_q       <= 3'd0;
      led_vld_q   <= 1'b0;
      key_emu_q   <= pkcr_pkg::KeyEmuReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == pkcr_pkg::CFG_KEY_EMU) begin
        key_emu_q <= cfg_data_i[0];
      end else if (cfg_index_i == pkcr_pkg::CFG_INIT_SET) begin
        set_q <= cfg_data_i[7:0];
      end
    end else if (accept_i) begin
      phase_q     <= phase_d;
      last_sent_q <= last_sent_d;
      enable_q    <= enable_d;
      set_q       <= set_d;
      table_q     <= table_d;
      led_q       <= led_d;
      led_vld_q   <= led_vld_d;
    end
  end

endmodule

### rtl/core/pkcr_queue.sv
// ----------------------------------------------------------------------------
// pkcr_queue: run descriptor queue
// Small register queue between decoder and response sender.
// ----------------------------------------------------------------------------
module pkcr_queue #(
  parameter int unsigned Depth = pkcr_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pkcr_pkg::run_t push_data_i,
  input  logic           pop_i,
  output pkcr_pkg::run_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  pkcr_pkg::run_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/core/pkcr_back.sv
// ----------------------------------------------------------------------------
// pkcr_back: response sender
// Walks the head run one byte per beat into the output register.
// ----------------------------------------------------------------------------
module pkcr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pkcr_pkg::run_t    head_i,
  input  logic              head_valid_i,
  output logic              pop_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [7:0]        tx_byte_o,
  output logic              last_of_run_o,
  output pkcr_pkg::status_t status_o
);

  logic [pkcr_pkg::RunIdxW-1:0] idx_q;
  logic                         out_valid_q;
  logic [7:0]                   tx_byte_q;
  logic                         last_q;
  pkcr_pkg::status_t            status_q;
  logic                         load;
  logic                         is_last;

  assign load    = head_valid_i && (!out_valid_q || !out_stall_i);
  assign is_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? '0 : idx_q + 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tx_byte_q <= head_i.bytes[idx_q];
      last_q    <= is_last;
      status_q  <= head_i.status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tx_byte_o     = tx_byte_q;
  assign last_of_run_o = last_q;
  assign status_o      = status_q;

endmodule

### rtl/core/ps2_keyboard_command_responder_core.sv
// ----------------------------------------------------------------------------
// ps2_keyboard_command_responder_core: PS/2 keyboard host command responder
// Keyboard side of the host command set: takes host bytes, answers with a
// run of one to three response bytes and reports the keyboard state.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                Payload
//  -------   ---------  -----------------------  ---------------------------------
//  in        to core    in_valid_i / in_stall_o  rx_byte_i, rx_error_i
//  out       from core  out_valid_o / out_stall_i tx_byte_o, last_of_run_o, status
//  cfg       to core    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  An item has one to three response bytes; the sender moves one byte per beat
//  out of its output register.
//  The decoder takes a new byte every cycle while the run queue has room; it
//  stalls the input only when the queue is full.
//  A stall on the output holds the output register; the decoder keeps filling
//  the queue behind it.
//  Reset clears all control state at once; no clearing pass is needed.
//
module ps2_keyboard_command_responder_core #(
  parameter int unsigned QueueDepth = pkcr_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // host byte channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          rx_error_i,
  // response channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    tx_byte_o,
  output logic                          last_of_run_o,
  output logic                          kbd_enabled_o,
  output logic [2:0]                    led_bits_o,
  output logic                          leds_valid_o,
  output logic [7:0]                    current_set_o,
  output logic [1:0]                    table_choice_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pkcr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pkcr_pkg::CfgDataW-1:0] cfg_data_i
);

  logic              accept;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  pkcr_pkg::run_t    run_in;
  pkcr_pkg::run_t    run_head;
  pkcr_pkg::status_t status;

  // Always take register writes; a write blocks the state update of a host byte accepted with it
  assign cfg_ready_o = 1'b1;

  // Hold the host side only while the queue has no free slot
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // Decode the beat and update keyboard state on acceptance
  pkcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .rx_error_i  (rx_error_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .run_o       (run_in)
  );

  // Buffer decoded runs so decoder and sender stall independently
  pkcr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (run_in),
    .pop_i       (q_pop),
    .head_o      (run_head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  // Send the run one byte per beat; pop on its final byte
  pkcr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (run_head),
    .head_valid_i  (!q_empty),
    .pop_o         (q_pop),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .tx_byte_o     (tx_byte_o),
    .last_of_run_o (last_of_run_o),
    .status_o      (status)
  );

  assign kbd_enabled_o  = status.kbd_enabled;
  assign led_bits_o     = status.led_bits;
  assign leds_valid_o   = status.leds_valid;
  assign current_set_o  = status.current_set;
  assign table_choice_o = status.table_choice;

endmodule

### rtl/core/pkcr_checker.sv
// ----------------------------------------------------------------------------
// pkcr_checker: port-level checks of the command responder
// Watches the top-level ports for response run and output register behavior.
// ----------------------------------------------------------------------------
module pkcr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] tx_byte_o,
  input logic       last_of_run_o,
  input logic       kbd_enabled_o,
  input logic [2:0] led_bits_o,
  input logic       leds_valid_o,
  input logic [7:0] current_set_o,
  input logic [1:0] table_choice_o
);

  // A stalled response beat holds its byte
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tx_byte_o) &&
                                   $stable(last_of_run_o))
    else $error("stalled response beat changed");

  // The rest of a run follows with no gap and the same status
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=>
      out_valid_o && $stable(kbd_enabled_o) && $stable(led_bits_o) &&
      $stable(leds_valid_o) && $stable(current_set_o) && $stable(table_choice_o))
    else $error("response run broken or status changed mid-run");

  // Nothing leaves the output register straight out of reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("response beat right after reset");

endmodule

bind ps2_keyboard_command_responder_core pkcr_checker u_pkcr_checker (.*);

### dv/ps2_response_checker.sv
// ----------------------------------------------------------------------------
// ps2_response_checker: response predictor and comparator for the command responder
// Watches the host byte, response and register write channels. Each accepted
// host byte is run through a local copy of the keyboard command state. The
// response bytes it should cause are queued. Each response beat is compared
// field by field against the oldest queued byte.
// ----------------------------------------------------------------------------
module ps2_response_checker
  import pkcr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                rx_error_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic [7:0]          tx_byte_o,
  input  logic                last_of_run_o,
  input  logic                kbd_enabled_o,
  input  logic [2:0]          led_bits_o,
  input  logic                leds_valid_o,
  input  logic [7:0]          current_set_o,
  input  logic [1:0]          table_choice_o,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         awaited_count_o
);

  typedef enum logic [1:0] {
    PhIdle,
    PhTypematic,
    PhSet,
    PhLeds
  } arg_phase_e;

  typedef struct packed {
    byte_t   tx;
    logic    last;
    status_t status;
  } response_t;

  // Keyboard state as the host would see it
  logic       key_emu;
  arg_phase_e phase;
  byte_t      last_byte;
  logic       enabled;
  byte_t      stored_set;
  logic [1:0] table_sel;
  logic [2:0] leds;
  logic       leds_ok;

  response_t   awaited_responses[$];
  byte_t       run_bytes[$];
  int unsigned beat_count;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("response beat %0d: %s is %0h, predicted %0h", beat_count, what, got, want);
    fail_count_o++;
  endtask

  // The resend request itself is never remembered as the last byte sent
  function automatic void send_response(input byte_t b);
    run_bytes.push_back(b);
    if (b != RSP_RESEND) last_byte = b;
  endfunction

  function automatic void decode_command(input byte_t b, input logic err);
    if (err || b < CMD_LEDS || b == CMD_BAD_F1 || b == CMD_BAD_EF) begin
      send_response(RSP_RESEND);
      return;
    end
    case (b)
      CMD_RESET: begin
        enabled   = 1'b0;
        last_byte = '0;
        send_response(RSP_ACK);
        if (key_emu) send_response(RSP_BAT_OK);
      end
      CMD_RESEND: send_response(last_byte);
      CMD_ENABLE: begin
        enabled = 1'b1;
        send_response(RSP_ACK);
      end
      CMD_READ_ID: begin
        send_response(RSP_ACK);
        send_response(RSP_ID_LO);
        send_response(RSP_ID_HI);
        enabled = 1'b1;
      end
      CMD_ECHO: send_response(RSP_ECHO);
      CMD_TYPEMATIC: begin
        send_response(RSP_ACK);
        phase = PhTypematic;
      end
      CMD_SET: begin
        send_response(RSP_ACK);
        phase = PhSet;
      end
      CMD_LEDS: begin
        send_response(RSP_ACK);
        phase = PhLeds;
      end
      default: send_response(RSP_ACK);
    endcase
  endfunction

  function automatic void take_argument(input byte_t b);
    arg_phase_e was;
    was   = phase;
    phase = PhIdle;
    case (was)
      PhSet: begin
        if (b == '0) begin
          send_response(RSP_ACK);
          send_response(stored_set);
        end else begin
          stored_set = b;
          if (b >= 8'd1 && b <= 8'd3) table_sel = b[1:0];
          send_response(RSP_ACK);
        end
      end
      PhLeds: begin
        if (b < LED_ARG_LIMIT) begin
          leds    = b[2:0];
          leds_ok = 1'b1;
        end
        send_response(RSP_ACK);
      end
      default: send_response(RSP_ACK);
    endcase
  endfunction

  function automatic void answer_host_byte(input byte_t b, input logic err);
    status_t   now;
    response_t rsp;
    run_bytes.delete();
    if (phase == PhIdle) begin
      decode_command(b, err);
    end else if (err) begin
      send_response(RSP_RESEND);
    end else begin
      take_argument(b);
    end
    now = {enabled, leds, leds_ok, stored_set, table_sel};
    foreach (run_bytes[k]) begin
      rsp.tx     = run_bytes[k];
      rsp.last   = (k == run_bytes.size() - 1);
      rsp.status = now;
      awaited_responses.push_back(rsp);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    response_t want;
    if (!rst_ni) begin
      key_emu    = KeyEmuReset;
      phase      = PhIdle;
      last_byte  = '0;
      enabled    = 1'b0;
      stored_set = InitSetReset;
      table_sel  = '0;
      leds       = '0;
      leds_ok    = 1'b0;
      awaited_responses.delete();
      beat_count   = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_KEY_EMU:  key_emu = cfg_data_i[0];
          CFG_INIT_SET: stored_set = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) answer_host_byte(rx_byte_i, rx_error_i);
      if (out_valid_o && !out_stall_i) begin
        if (awaited_responses.size() == 0) begin
          report_mismatch("unpredicted response, tx_byte", tx_byte_o, '0);
        end else begin
          want = awaited_responses.pop_front();
          if (tx_byte_o != want.tx) report_mismatch("tx_byte", tx_byte_o, want.tx);
          if (last_of_run_o != want.last)
            report_mismatch("last_of_run", last_of_run_o, want.last);
          if (kbd_enabled_o != want.status.kbd_enabled)
            report_mismatch("kbd_enabled", kbd_enabled_o, want.status.kbd_enabled);
          if (led_bits_o != want.status.led_bits)
            report_mismatch("led_bits", led_bits_o, want.status.led_bits);
          if (leds_valid_o != want.status.leds_valid)
            report_mismatch("leds_valid", leds_valid_o, want.status.leds_valid);
          if (current_set_o != want.status.current_set)
            report_mismatch("current_set", current_set_o, want.status.current_set);
          if (table_choice_o != want.status.table_choice)
            report_mismatch("table_choice", table_choice_o, want.status.table_choice);
        end
        beat_count++;
      end
    end
    awaited_count_o = awaited_responses.size();
  end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the PS/2 keyboard command responder
// Drives host bytes with random gaps and random output stalls, writes the
// configuration registers between traffic phases, and leaves all prediction
// and comparison to the response checker instantiated beside the core.
// ----------------------------------------------------------------------------
module testbench;
  import pkcr_pkg::*;

  // Far above the slowest legal run: ~250 bytes, three responses each,
  // 82% output stall and 82% sender gaps at worst.
  localparam int unsigned CycleLimit  = 200000;
  // Cycles to keep watching the response channel after the last beat
  localparam int unsigned DrainCycles = 16;

  // All inputs start at a known value before time zero
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic [7:0]          rx_byte_i   = '0;
  logic                rx_error_i  = 1'b0;
  logic                out_stall_i = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] tx_byte_o;
  logic       last_of_run_o;
  logic       kbd_enabled_o;
  logic [2:0] led_bits_o;
  logic       leds_valid_o;
  logic [7:0] current_set_o;
  logic [1:0] table_choice_o;
  logic       cfg_ready_o;

  int unsigned fail_count;
  int unsigned awaited_count;
  int unsigned cycles;

  // Percent of cycles in which the host side holds off / the response side stalls
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Directed beats, {rx_error, rx_byte}, run with key emulation on and set 2
  logic [8:0] directed_beats [26] = '{
    {1'b0, CMD_READ_ID},     // FA AB 83, enables scanning
    {1'b0, CMD_RESEND},      // repeats 83
    {1'b0, CMD_ECHO},        // EE
    {1'b0, 8'h00},           // lowest byte, below the command range
    {1'b0, 8'hEC},           // just below the command range
    {1'b0, CMD_BAD_F1},      // rejected command
    {1'b0, CMD_BAD_EF},      // rejected command
    {1'b1, CMD_ENABLE},      // framing error on a valid command
    {1'b0, CMD_RESEND},      // resend request is not remembered: repeats EE
    {1'b0, CMD_RESET},       // FA AA, clears enable
    {1'b0, CMD_ENABLE},
    {1'b0, CMD_LEDS},
    {1'b1, 8'h05},           // error in argument phase: stays waiting
    {1'b0, 8'h05},           // LEDs loaded and marked valid
    {1'b0, CMD_LEDS},
    {1'b0, 8'h07},           // excluded LED value: LEDs kept
    {1'b0, CMD_SET},
    {1'b0, 8'h00},           // reports the stored set
    {1'b0, CMD_SET},
    {1'b0, 8'h03},           // stores 3 and selects table 3
    {1'b0, CMD_SET},
    {1'b0, 8'hFF},           // stores FF, table kept
    {1'b0, CMD_TYPEMATIC},
    {1'b0, 8'hFF},           // any typematic value is acknowledged
    {1'b0, 8'hF5},           // plain acknowledged command
    {1'b1, 8'hFF}            // highest byte with an error
  };

  ps2_keyboard_command_responder_core dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .rx_byte_i,
    .rx_error_i,
    .out_valid_o,
    .out_stall_i,
    .tx_byte_o,
    .last_of_run_o,
    .kbd_enabled_o,
    .led_bits_o,
    .leds_valid_o,
    .current_set_o,
    .table_choice_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  ps2_response_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .rx_byte_i,
    .rx_error_i,
    .out_valid_o,
    .out_stall_i,
    .tx_byte_o,
    .last_of_run_o,
    .kbd_enabled_o,
    .led_bits_o,
    .leds_valid_o,
    .current_set_o,
    .table_choice_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .fail_count_o    (fail_count),
    .awaited_count_o (awaited_count)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Response side: decide the stall for the coming edge at every falling edge
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: end the run if it never completes
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[ps2_keyboard_command_responder_core] ERROR");
    $finish;
  end

  // Send one host byte: hold off at random, then present the beat and hold it
  // until the core takes it. Returns at a falling edge with valid still high.
  task automatic send_host_byte(input byte_t b, input logic err);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    rx_error_i = err;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted response has left the core
  task automatic settle();
    in_valid_i = 1'b0;
    while (awaited_count != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Commands that pass decoding, weighted toward the ones with state effects
  function automatic byte_t pick_command();
    case ($urandom_range(9))
      0:       return CMD_LEDS;
      1:       return CMD_ECHO;
      2:       return CMD_SET;
      3:       return CMD_READ_ID;
      4:       return CMD_TYPEMATIC;
      5:       return CMD_ENABLE;
      6:       return CMD_RESEND;
      7:       return CMD_RESET;
      default: return byte_t'(8'hF5 + $urandom_range(8));
    endcase
  endfunction

  // Set and LED arguments half the time in the interesting range, otherwise anything at all
  function automatic byte_t pick_argument(input byte_t cmd);
    int unsigned r;
    r = $urandom_range(3);
    if (cmd == CMD_SET) begin
      if (r == 0) return '0;
      if (r == 1) return byte_t'($urandom_range(3, 1));
    end else if (cmd == CMD_LEDS && r < 2) begin
      return byte_t'($urandom_range(7));
    end
    return byte_t'($urandom_range(255));
  endfunction

  // Random traffic: mostly well-formed command/argument exchanges, the rest
  // raw noise and random bytes of the command range, some with an error.
  task automatic random_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned kind;
    byte_t       cmd;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 65) begin
        cmd = pick_command();
        send_host_byte(cmd, 1'b0);
        sent++;
        if (cmd == CMD_LEDS || cmd == CMD_SET || cmd == CMD_TYPEMATIC) begin
          // a damaged argument first, now and then
          if ($urandom_range(9) == 0) begin
            send_host_byte(byte_t'($urandom_range(255)), 1'b1);
            sent++;
          end
          send_host_byte(pick_argument(cmd), 1'b0);
          sent++;
        end
      end else if (kind < 85) begin
        send_host_byte(byte_t'($urandom_range(255)), ($urandom_range(3) == 0));
        sent++;
      end else begin
        send_host_byte(byte_t'(CMD_LEDS + $urandom_range(18)), ($urandom_range(4) == 0));
        sent++;
      end
    end
  endtask

  initial begin
    // Hold reset, then release it on a falling edge
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, no gaps or stalls, reset-value settings written explicitly
    write_reg(CFG_KEY_EMU, 8'h01);
    write_reg(CFG_INIT_SET, 8'h02);
    foreach (directed_beats[i]) send_host_byte(directed_beats[i][7:0], directed_beats[i][8]);
    settle();

    // Phase one: light host gaps, heavy response stall, key emulation off, set 0.
    // Also write an index that does not exist.
    write_reg(CFG_KEY_EMU, 8'h00);
    write_reg(CFG_INIT_SET, 8'h00);
    write_reg(CfgIdxW'(2), 8'h5A);
    send_idle_pct  = 25;
    recv_stall_pct = 82;
    random_traffic(30);
    // Hold the host off until the core has drained completely
    settle();
    random_traffic(30);
    settle();

    // Phase two: heavy host gaps, light stall, all-ones register data
    write_reg(CFG_KEY_EMU, 8'hFF);
    write_reg(CFG_INIT_SET, 8'hFF);
    write_reg(CfgIdxW'(8'hFF), 8'hFF);
    send_idle_pct  = 82;
    recv_stall_pct = 25;
    random_traffic(66);
    settle();

    // Phase three: back to back in both directions
    write_reg(CFG_KEY_EMU, 8'h01);
    write_reg(CFG_INIT_SET, 8'h03);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_traffic(66);
    settle();

    // Watch a little longer for stray response beats
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[ps2_keyboard_command_responder_core] OK");
    end else begin
      $display("[ps2_keyboard_command_responder_core] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/pkcr_pkg.sv
rtl/core/pkcr_front.sv
rtl/core/pkcr_queue.sv
rtl/core/pkcr_back.sv
rtl/core/ps2_keyboard_command_responder_core.sv
rtl/core/pkcr_checker.sv
dv/ps2_response_checker.sv
dv/testbench.sv
